### rtl/rte_pkg.sv
package rte_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = $clog2(QDepth);
  localparam int unsigned QCntW  = QAddrW + 1;
  localparam int unsigned UnitIdxW = 3;

  localparam logic [15:0] ChBackslash = 16'h005C;
  localparam logic [15:0] ChLowerX    = 16'h0078;
  localparam logic [15:0] ChLowerU    = 16'h0075;

  typedef enum logic [2:0] {
    ESC_LIT  = 3'd0,
    ESC_CHAR = 3'd1,
    ESC_HEX2 = 3'd2,
    ESC_HEX4 = 3'd3,
    ESC_PAIR = 3'd4
  } esc_kind_e;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        string_start;
    logic        string_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_unit;
    logic        last_of_item;
    logic        end_of_string;
  } out_item_t;

  // one escaped code point: kind plus value (pair kind holds cp - 0x10000)
  typedef struct packed {
    esc_kind_e   kind;
    logic [19:0] value;
  } seg_t;

  // all work for one input item: an optional flushed lone lead, then an optional code point
  typedef struct packed {
    logic        lead_valid;
    logic [15:0] lead;
    logic        cp_valid;
    seg_t        cp;
    logic        eos;
  } cmd_t;

  function automatic logic is_alnum(input logic [15:0] u);
    return (u >= 16'h0030 && u <= 16'h0039) || (u >= 16'h0041 && u <= 16'h005A) ||
           (u >= 16'h0061 && u <= 16'h007A);
  endfunction

  function automatic logic is_syntax(input logic [15:0] u);
    logic r;
    case (u)
      16'h005E, 16'h0024, 16'h005C, 16'h002E, 16'h002A, 16'h002B, 16'h003F,
      16'h0028, 16'h0029, 16'h005B, 16'h005D, 16'h007B, 16'h007D, 16'h007C,
      16'h002F: r = 1'b1;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_punct(input logic [15:0] u);
    logic r;
    case (u)
      16'h002C, 16'h002D, 16'h003D, 16'h003C, 16'h003E, 16'h0023, 16'h0026,
      16'h0021, 16'h0025, 16'h003A, 16'h003B, 16'h0040, 16'h007E, 16'h0027,
      16'h0060, 16'h0022: r = 1'b1;
      default:            r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_white(input logic [15:0] u);
    return (u >= 16'h0009 && u <= 16'h000D) || u == 16'h0020 || u == 16'h00A0 ||
           u == 16'h1680 || (u >= 16'h2000 && u <= 16'h200A) || u == 16'h2028 ||
           u == 16'h2029 || u == 16'h202F || u == 16'h205F || u == 16'h3000 ||
           u == 16'hFEFF;
  endfunction

  // escape plan for a code point inside the basic plane
  function automatic seg_t classify(input logic [15:0] u, input logic first);
    seg_t s;
    s.kind  = ESC_LIT;
    s.value = {4'h0, u};
    if (first && is_alnum(u)) begin
      s.kind = ESC_HEX2;
    end else if (is_syntax(u)) begin
      s.kind = ESC_CHAR;
    end else if (u >= 16'h0009 && u <= 16'h000D) begin
      s.kind = ESC_CHAR;
      case (u[3:0])
        4'h9:    s.value = 20'h00074;
        4'hA:    s.value = 20'h0006E;
        4'hB:    s.value = 20'h00076;
        4'hC:    s.value = 20'h00066;
        default: s.value = 20'h00072;
      endcase
    end else if (is_punct(u) || is_white(u) || u[15:11] == 5'b11011) begin
      s.kind = (u[15:8] == 8'h00) ? ESC_HEX2 : ESC_HEX4;
    end
    return s;
  endfunction

  function automatic logic [UnitIdxW-1:0] kind_len(input esc_kind_e k);
    logic [UnitIdxW-1:0] n;
    case (k)
      ESC_LIT:  n = UnitIdxW'(1);
      ESC_CHAR: n = UnitIdxW'(2);
      ESC_HEX2: n = UnitIdxW'(4);
      ESC_HEX4: n = UnitIdxW'(6);
      ESC_PAIR: n = UnitIdxW'(2);
      default:  n = UnitIdxW'(1);
    endcase
    return n;
  endfunction

  function automatic logic [15:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    c = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
    return {8'h00, c};
  endfunction

endpackage

### rtl/rte_front.sv
module rte_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  rte_pkg::in_item_t item_i,
  output logic              cmd_push_o,
  output rte_pkg::cmd_t     cmd_o
);

  logic [15:0] pend_lead_q, pend_lead_d;
  logic        pend_valid_q, pend_valid_d;
  logic        at_start_q, at_start_d;

  logic        ast, pv, is_lead, is_trail, hold, emitted;
  logic [15:0] u;
  rte_pkg::cmd_t cmd;

  always_comb begin
    u        = item_i.code_unit;
    ast      = item_i.string_start | at_start_q;
    pv       = ~item_i.string_start & pend_valid_q;
    is_lead  = (u[15:10] == 6'b110110);
    is_trail = (u[15:10] == 6'b110111);
    hold     = 1'b0;
    cmd      = '0;
    cmd.eos  = item_i.string_end;
    if (pv && is_trail) begin
      cmd.cp_valid = 1'b1;
      cmd.cp.kind  = rte_pkg::ESC_PAIR;
      cmd.cp.value = {pend_lead_q[9:0], u[9:0]};
    end else begin
      cmd.lead_valid = pv;
      cmd.lead       = pend_lead_q;
      if (is_lead && !item_i.string_end) begin
        hold = 1'b1;
      end else begin
        cmd.cp_valid = 1'b1;
        // a flushed lead takes the first position of the string
        cmd.cp       = rte_pkg::classify(u, ast & ~pv);
      end
    end
    emitted = cmd.lead_valid | cmd.cp_valid;
  end

  always_comb begin
    pend_lead_d  = pend_lead_q;
    pend_valid_d = pend_valid_q;
    at_start_d   = at_start_q;
    if (accept_i) begin
      pend_valid_d = hold;
      pend_lead_d  = hold ? u : 16'h0000;
      at_start_d   = item_i.string_end | (ast & ~emitted);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_lead_q  <= 16'h0000;
      pend_valid_q <= 1'b0;
      at_start_q   <= 1'b1;
    end else begin
      pend_lead_q  <= pend_lead_d;
      pend_valid_q <= pend_valid_d;
      at_start_q   <= at_start_d;
    end
  end

  assign cmd_push_o = accept_i & emitted;
  assign cmd_o      = cmd;

endmodule

### rtl/rte_cmd_queue.sv
module rte_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rte_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output rte_pkg::cmd_t head_o,
  output logic          empty_o
);

  rte_pkg::cmd_t mem_q [rte_pkg::QDepth];

  logic [rte_pkg::QAddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [rte_pkg::QCntW-1:0]  count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == rte_pkg::QCntW'(rte_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + rte_pkg::QAddrW'(do_push);
    rd_ptr_d = rd_ptr_q + rte_pkg::QAddrW'(do_pop);
    count_d  = count_q + rte_pkg::QCntW'(do_push) - rte_pkg::QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rte_pkg::QCntW'(rte_pkg::QDepth))
    else $error("queue count above depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("front pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("back popped an empty queue");

endmodule

### rtl/rte_back.sv
module rte_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rte_pkg::cmd_t      head_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  output rte_pkg::out_item_t out_item_o,
  input  logic               out_pop_i
);

  logic [rte_pkg::UnitIdxW-1:0] cnt_q, cnt_d;
  logic                         seg_q, seg_d;
  logic                         out_valid_q, out_valid_d;
  rte_pkg::out_item_t           out_q, out_d;

  logic              step, sel_cp, last_seg, last_entry;
  rte_pkg::esc_kind_e kind;
  logic [19:0]       val;
  logic [15:0]       unit;
  logic [3:0]        nib;

  assign step = ~q_empty_i & (~out_valid_q | out_pop_i);

  always_comb begin
    sel_cp     = seg_q | ~head_i.lead_valid;
    kind       = sel_cp ? head_i.cp.kind : rte_pkg::ESC_HEX4;
    val        = sel_cp ? head_i.cp.value : {4'h0, head_i.lead};
    last_seg   = (cnt_q == rte_pkg::kind_len(kind) - rte_pkg::UnitIdxW'(1));
    last_entry = last_seg & (sel_cp | ~head_i.cp_valid);
  end

  // digit selection for the hex forms
  always_comb begin
    case (cnt_q)
      3'd2:    nib = (kind == rte_pkg::ESC_HEX2) ? val[7:4] : val[15:12];
      3'd3:    nib = (kind == rte_pkg::ESC_HEX2) ? val[3:0] : val[11:8];
      3'd4:    nib = val[7:4];
      default: nib = val[3:0];
    endcase
  end

  always_comb begin
    unit = rte_pkg::ChBackslash;
    case (kind)
      rte_pkg::ESC_LIT: unit = val[15:0];
      rte_pkg::ESC_CHAR: begin
        if (cnt_q != '0) unit = val[15:0];
      end
      rte_pkg::ESC_HEX2, rte_pkg::ESC_HEX4: begin
        if (cnt_q == 3'd1) begin
          unit = (kind == rte_pkg::ESC_HEX2) ? rte_pkg::ChLowerX : rte_pkg::ChLowerU;
        end else if (cnt_q != '0) begin
          unit = rte_pkg::hex_char(nib);
        end
      end
      rte_pkg::ESC_PAIR: begin
        unit = (cnt_q == '0) ? {6'b110110, val[19:10]} : {6'b110111, val[9:0]};
      end
      default: unit = val[15:0];
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    seg_d       = seg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_pop_i;
    if (step) begin
      out_valid_d         = 1'b1;
      out_d.out_unit      = unit;
      out_d.last_of_item  = last_entry;
      out_d.end_of_string = last_entry & head_i.eos;
      if (last_entry) begin
        cnt_d = '0;
        seg_d = 1'b0;
      end else if (last_seg) begin
        cnt_d = '0;
        seg_d = 1'b1;
      end else begin
        cnt_d = cnt_q + rte_pkg::UnitIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      seg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign q_pop_o     = step & last_entry;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd5)
    else $error("unit index out of range");
  a_seg_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q |-> (!q_empty_i && head_i.lead_valid && head_i.cp_valid))
    else $error("second segment selected without a code point");
  a_mid_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> !q_empty_i)
    else $error("entry lost while expanding");
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (out_valid_q && out_q.last_of_item))
    else $error("queue popped without a last unit");

endmodule

### rtl/regex_text_escaper.sv
// path: an accepted item's command is queued, then its units are registered in the output stage
// throughput: one input item per cycle while the command queue has room; the back end
// emits one output unit per cycle while the receiver keeps popping, up to 12 units per item
// a held lead surrogate yields no output until the next unit arrives; a new string start drops it
// reset: asynchronous, active low; queue and output stage empty, no lead held,
// next code point treated as the first of a string
module regex_text_escaper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  rte_pkg::in_item_t  in_item_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output rte_pkg::out_item_t out_item_o
);

  logic          accept, cmd_push, q_full, q_empty, q_pop, out_valid;
  rte_pkg::cmd_t cmd, head;

  assign full   = q_full;
  assign accept = push & ~q_full;
  assign empty  = ~out_valid;

  rte_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_item_i),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd)
  );

  rte_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (head),
    .empty_o(q_empty)
  );

  rte_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid),
    .out_item_o (out_item_o),
    .out_pop_i  (pop)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef enum int {
    PH_NO_IDLE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH_IDLE
  } phase_e;

  localparam int unsigned RandomUnitsPerPhase = 125;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned MaxReports = 10;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  rte_pkg::in_item_t  in_item = '0;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  rte_pkg::out_item_t out_item;

  phase_e      phase = PH_NO_IDLE;
  int unsigned mismatch_count = 0;

  // predictor state
  logic [15:0]        held_lead = '0;
  logic               lead_held = 1'b0;
  logic               first_cp = 1'b1;
  logic [15:0]        escaped_units[$];
  rte_pkg::out_item_t expected_units[$];

  regex_text_escaper dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_item_i (in_item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [15:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? (16'h0030 + 16'(nib)) : (16'h0061 + 16'(nib) - 16'd10);
  endfunction

  function automatic bit is_word_char(input logic [20:0] cp);
    return (cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h41 && cp <= 21'h5A) ||
           (cp >= 21'h61 && cp <= 21'h7A);
  endfunction

  function automatic bit is_regex_syntax(input logic [20:0] cp);
    case (cp)
      21'h5E, 21'h24, 21'h5C, 21'h2E, 21'h2A, 21'h2B, 21'h3F, 21'h28, 21'h29,
      21'h5B, 21'h5D, 21'h7B, 21'h7D, 21'h7C, 21'h2F: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_hex_punct(input logic [20:0] cp);
    case (cp)
      21'h2C, 21'h2D, 21'h3D, 21'h3C, 21'h3E, 21'h23, 21'h26, 21'h21, 21'h25,
      21'h3A, 21'h3B, 21'h40, 21'h7E, 21'h27, 21'h60, 21'h22: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_js_space(input logic [20:0] cp);
    return (cp >= 21'h09 && cp <= 21'h0D) || cp == 21'h20 || cp == 21'hA0 ||
           cp == 21'h1680 || (cp >= 21'h2000 && cp <= 21'h200A) || cp == 21'h2028 ||
           cp == 21'h2029 || cp == 21'h202F || cp == 21'h205F || cp == 21'h3000 ||
           cp == 21'hFEFF;
  endfunction

  function automatic void put_hex(input logic [20:0] cp, input int digits);
    for (int d = digits - 1; d >= 0; d--) begin
      escaped_units.push_back(hex_digit(cp[d*4 +: 4]));
    end
  endfunction

  function automatic void escape_code_point(input logic [20:0] cp);
    logic        first;
    logic [19:0] offs;
    first = first_cp;
    first_cp = 1'b0;
    if (first && is_word_char(cp)) begin
      escaped_units.push_back(rte_pkg::ChBackslash);
      escaped_units.push_back(rte_pkg::ChLowerX);
      put_hex(cp, 2);
    end else if (is_regex_syntax(cp)) begin
      escaped_units.push_back(rte_pkg::ChBackslash);
      escaped_units.push_back(cp[15:0]);
    end else if (cp >= 21'h09 && cp <= 21'h0D) begin
      escaped_units.push_back(rte_pkg::ChBackslash);
      case (cp[3:0])
        4'h9:    escaped_units.push_back(16'h0074); // t
        4'hA:    escaped_units.push_back(16'h006E); // n
        4'hB:    escaped_units.push_back(16'h0076); // v
        4'hC:    escaped_units.push_back(16'h0066); // f
        default: escaped_units.push_back(16'h0072); // r
      endcase
    end else if (is_hex_punct(cp) || is_js_space(cp) || (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
      escaped_units.push_back(rte_pkg::ChBackslash);
      if (cp <= 21'hFF) begin
        escaped_units.push_back(rte_pkg::ChLowerX);
        put_hex(cp, 2);
      end else begin
        escaped_units.push_back(rte_pkg::ChLowerU);
        put_hex(cp, 4);
      end
    end else if (cp <= 21'hFFFF) begin
      escaped_units.push_back(cp[15:0]);
    end else begin
      offs = 20'(cp - 21'h10000);
      escaped_units.push_back(16'hD800 + 16'(offs[19:10]));
      escaped_units.push_back(16'hDC00 + 16'(offs[9:0]));
    end
  endfunction

  // expected output units for one accepted item
  function automatic void escape_item(input rte_pkg::in_item_t it);
    logic [15:0]        u;
    rte_pkg::out_item_t r;
    u = it.code_unit;
    escaped_units.delete();
    if (it.string_start) begin
      lead_held = 1'b0;
      held_lead = '0;
      first_cp = 1'b1;
    end
    if (lead_held && u >= 16'hDC00 && u <= 16'hDFFF) begin
      lead_held = 1'b0;
      escape_code_point(21'h10000 + {1'b0, held_lead[9:0], u[9:0]});
      held_lead = '0;
    end else begin
      // a held lead not followed by a trail goes out as a lone surrogate
      if (lead_held) begin
        lead_held = 1'b0;
        escape_code_point({5'h0, held_lead});
        held_lead = '0;
      end
      if (u >= 16'hD800 && u <= 16'hDBFF && !it.string_end) begin
        held_lead = u;
        lead_held = 1'b1;
      end else begin
        escape_code_point({5'h0, u});
      end
    end
    if (it.string_end) begin
      lead_held = 1'b0;
      held_lead = '0;
      first_cp = 1'b1;
    end
    foreach (escaped_units[k]) begin
      r.out_unit = escaped_units[k];
      r.last_of_item = (k == escaped_units.size() - 1);
      r.end_of_string = r.last_of_item && it.string_end;
      expected_units.push_back(r);
    end
  endfunction

  function automatic bit sender_waits();
    case (phase)
      PH_SEND_IDLE: return $urandom_range(99) < 88;
      PH_BOTH_IDLE: return $urandom_range(99) < 18;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (phase)
      PH_RECV_STALL: return $urandom_range(99) < 88;
      PH_BOTH_IDLE:  return $urandom_range(99) < 18;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic send_unit(input logic [15:0] u, input logic s, input logic e);
    rte_pkg::in_item_t it;
    it.code_unit = u;
    it.string_start = s;
    it.string_end = e;
    @(negedge clk_i);
    while (sender_waits()) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full !== 1'b0) @(posedge clk_i);
    escape_item(it);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= !receiver_stalls();
    end
  end

  always @(posedge clk_i) begin
    rte_pkg::out_item_t want;
    if (rst_ni && pop && empty === 1'b0) begin
      if (expected_units.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("unexpected unit %h last %b eos %b", out_item.out_unit,
                   out_item.last_of_item, out_item.end_of_string);
      end else begin
        want = expected_units.pop_front();
        if (out_item.out_unit !== want.out_unit ||
            out_item.last_of_item !== want.last_of_item ||
            out_item.end_of_string !== want.end_of_string) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("mismatch: expected unit %h last %b eos %b, got unit %h last %b eos %b",
                     want.out_unit, want.last_of_item, want.end_of_string,
                     out_item.out_unit, out_item.last_of_item, out_item.end_of_string);
        end
      end
    end
  end

  task automatic test_first_alnum();
    send_unit(16'h0061, 1'b1, 1'b0); // first code point gets hex form
    send_unit(16'h005A, 1'b0, 1'b0);
    send_unit(16'h0030, 1'b0, 1'b0);
    send_unit(16'h0039, 1'b0, 1'b1);
  endtask

  task automatic test_unit_extremes();
    send_unit(16'h0000, 1'b1, 1'b1);
    send_unit(16'hFFFF, 1'b1, 1'b1);
  endtask

  task automatic test_escape_classes();
    send_unit(16'h005E, 1'b1, 1'b0);
    send_unit(16'h002F, 1'b0, 1'b0);
    send_unit(16'h0009, 1'b0, 1'b0);
    send_unit(16'h000D, 1'b0, 1'b0);
    send_unit(16'h002C, 1'b0, 1'b0);
    send_unit(16'h00A0, 1'b0, 1'b0);
    send_unit(16'h3000, 1'b0, 1'b1);
  endtask

  task automatic test_surrogates();
    send_unit(16'hD800, 1'b1, 1'b0);
    send_unit(16'hDC00, 1'b0, 1'b0);
    send_unit(16'hDBFF, 1'b0, 1'b0);
    send_unit(16'hDFFF, 1'b0, 1'b0);
    send_unit(16'hD800, 1'b0, 1'b0); // lead flushed by a non-trail
    send_unit(16'h0078, 1'b0, 1'b0);
    send_unit(16'hDC00, 1'b0, 1'b0); // trail with nothing held
    send_unit(16'hDBFF, 1'b0, 1'b1); // lead on the last unit stands alone
  endtask

  task automatic test_string_marks();
    send_unit(16'hD900, 1'b1, 1'b0);
    send_unit(16'h0061, 1'b1, 1'b0); // new start drops the held lead
    send_unit(16'h002E, 1'b0, 1'b1);
    send_unit(16'h0063, 1'b0, 1'b1); // no start mark, still a fresh string
  endtask

  function automatic logic [15:0] random_bmp_unit();
    case ($urandom_range(7))
      0: return 16'($urandom_range(16'hFFFF));
      1: return 16'($urandom_range(8'h1F));
      2: return 16'($urandom_range(8'h80, 8'hFF));
      3: begin
        case ($urandom_range(6))
          0: return 16'h0020;
          1: return 16'h00A0;
          2: return 16'h1680;
          3: return 16'h2000 + 16'($urandom_range(10));
          4: return 16'h2028 + 16'($urandom_range(1));
          5: return ($urandom_range(1) != 0) ? 16'h202F : 16'h205F;
          default: return ($urandom_range(1) != 0) ? 16'h3000 : 16'hFEFF;
        endcase
      end
      4: begin
        case ($urandom_range(2))
          0: return 16'h0030 + 16'($urandom_range(9));
          1: return 16'h0041 + 16'($urandom_range(25));
          default: return 16'h0061 + 16'($urandom_range(25));
        endcase
      end
      default: return 16'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  // mostly well-formed strings, some with missing or stray marks
  task automatic test_random_text(input phase_e ph, input int unsigned n_units);
    logic [15:0] text[$];
    int unsigned sent;
    int unsigned len;
    logic        s_flag;
    logic        e_flag;
    bit          broken;
    phase = ph;
    sent = 0;
    while (sent < n_units) begin
      text.delete();
      len = $urandom_range(1, 10);
      while (text.size() < len) begin
        case ($urandom_range(11))
          0: begin
            text.push_back(16'hD800 | 16'($urandom_range(10'h3FF)));
            text.push_back(16'hDC00 | 16'($urandom_range(10'h3FF)));
          end
          1: text.push_back(16'hD800 + 16'($urandom_range(16'h7FF)));
          default: text.push_back(random_bmp_unit());
        endcase
      end
      broken = ($urandom_range(99) < 15);
      foreach (text[k]) begin
        s_flag = (k == 0);
        e_flag = (k == text.size() - 1);
        if (broken) begin
          s_flag = ($urandom_range(3) == 0);
          e_flag = ($urandom_range(3) == 0);
        end
        send_unit(text[k], s_flag, e_flag);
      end
      sent += text.size();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_first_alnum();
    test_unit_extremes();
    test_escape_classes();
    test_surrogates();
    test_string_marks();
    test_random_text(PH_NO_IDLE, RandomUnitsPerPhase);
    test_random_text(PH_SEND_IDLE, RandomUnitsPerPhase);
    test_random_text(PH_RECV_STALL, RandomUnitsPerPhase);
    test_random_text(PH_BOTH_IDLE, RandomUnitsPerPhase);
    @(negedge clk_i);
    push <= 1'b0;
    phase = PH_NO_IDLE;
    while (expected_units.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
